### rtl/usrs_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// usrs_pkg
// Shared types and constants for the UTF-8 script run segmenter: script
// codes, the codepoint range table, payload structs and decode patterns.
// ============================================================================
package usrs_pkg;

    // Script classes.
    localparam logic [4:0] SCR_UNKNOWN    = 5'd0;
    localparam logic [4:0] SCR_LATIN      = 5'd1;
    localparam logic [4:0] SCR_ARABIC     = 5'd2;
    localparam logic [4:0] SCR_HEBREW     = 5'd3;
    localparam logic [4:0] SCR_CYRILLIC   = 5'd4;
    localparam logic [4:0] SCR_GREEK      = 5'd5;
    localparam logic [4:0] SCR_THAI       = 5'd6;
    localparam logic [4:0] SCR_DEVANAGARI = 5'd7;
    localparam logic [4:0] SCR_BENGALI    = 5'd8;
    localparam logic [4:0] SCR_TAMIL      = 5'd9;
    localparam logic [4:0] SCR_TELUGU     = 5'd10;
    localparam logic [4:0] SCR_KANNADA    = 5'd11;
    localparam logic [4:0] SCR_MALAYALAM  = 5'd12;
    localparam logic [4:0] SCR_GUJARATI   = 5'd13;
    localparam logic [4:0] SCR_CJK        = 5'd14;
    localparam logic [4:0] SCR_EMOJI      = 5'd15;
    localparam logic [4:0] SCR_DIGIT      = 5'd16;
    localparam logic [4:0] SCR_NEUTRAL    = 5'd17;

    // UTF-8 lead byte patterns.
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_PAT  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_PAT  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_PAT  = 8'hF0;

    localparam logic [16:0] CNT_MAX = 17'h1FFFF;

    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        logic [20:0] lo;
        logic [20:0] hi;
        logic [4:0]  cls;
    } span_t;

    localparam int NUM_SPANS = 54;

    localparam span_t SPANS [NUM_SPANS] = '{
        '{21'h1F300, 21'h1F9FF, SCR_EMOJI},   '{21'h02600, 21'h026FF, SCR_EMOJI},
        '{21'h02700, 21'h027BF, SCR_EMOJI},   '{21'h0FE00, 21'h0FE0F, SCR_EMOJI},
        '{21'h1F000, 21'h1F02F, SCR_EMOJI},   '{21'h1F0A0, 21'h1F0FF, SCR_EMOJI},
        '{21'h1FA70, 21'h1FAFF, SCR_EMOJI},   '{21'h1F3FB, 21'h1F3FF, SCR_EMOJI},
        '{21'h0200D, 21'h0200D, SCR_EMOJI},   '{21'h1F1E6, 21'h1F1FF, SCR_EMOJI},
        '{21'h00030, 21'h00039, SCR_DIGIT},
        '{21'h00020, 21'h00020, SCR_NEUTRAL}, '{21'h0003A, 21'h0003A, SCR_NEUTRAL},
        '{21'h0002C, 21'h0002C, SCR_NEUTRAL}, '{21'h0002E, 21'h0002E, SCR_NEUTRAL},
        '{21'h0002D, 21'h0002D, SCR_NEUTRAL}, '{21'h00028, 21'h00028, SCR_NEUTRAL},
        '{21'h00029, 21'h00029, SCR_NEUTRAL}, '{21'h0003D, 21'h0003D, SCR_NEUTRAL},
        '{21'h00022, 21'h00022, SCR_NEUTRAL},
        '{21'h00041, 21'h0005A, SCR_LATIN},   '{21'h00061, 21'h0007A, SCR_LATIN},
        '{21'h000C0, 21'h000FF, SCR_LATIN},   '{21'h00100, 21'h0017F, SCR_LATIN},
        '{21'h00180, 21'h0024F, SCR_LATIN},
        '{21'h00600, 21'h006FF, SCR_ARABIC},  '{21'h0FB50, 21'h0FDFF, SCR_ARABIC},
        '{21'h0FE70, 21'h0FEFF, SCR_ARABIC},
        '{21'h00590, 21'h005FF, SCR_HEBREW},
        '{21'h00400, 21'h004FF, SCR_CYRILLIC}, '{21'h00500, 21'h0052F, SCR_CYRILLIC},
        '{21'h00370, 21'h003FF, SCR_GREEK},   '{21'h01F00, 21'h01FFF, SCR_GREEK},
        '{21'h00E00, 21'h00E7F, SCR_THAI},
        '{21'h00900, 21'h0097F, SCR_DEVANAGARI}, '{21'h00980, 21'h009FF, SCR_BENGALI},
        '{21'h00B80, 21'h00BFF, SCR_TAMIL},   '{21'h00C00, 21'h00C7F, SCR_TELUGU},
        '{21'h00C80, 21'h00CFF, SCR_KANNADA}, '{21'h00D00, 21'h00D7F, SCR_MALAYALAM},
        '{21'h00A80, 21'h00AFF, SCR_GUJARATI},
        '{21'h04E00, 21'h09FFF, SCR_CJK},     '{21'h03400, 21'h04DBF, SCR_CJK},
        '{21'h20000, 21'h2A6DF, SCR_CJK},     '{21'h2A700, 21'h2B73F, SCR_CJK},
        '{21'h2B740, 21'h2B81F, SCR_CJK},     '{21'h2B820, 21'h2CEAF, SCR_CJK},
        '{21'h0F900, 21'h0FAFF, SCR_CJK},     '{21'h03040, 21'h0309F, SCR_CJK},
        '{21'h030A0, 21'h030FF, SCR_CJK},     '{21'h031F0, 21'h031FF, SCR_CJK},
        '{21'h03190, 21'h0319F, SCR_CJK},     '{21'h0AC00, 21'h0D7AF, SCR_CJK},
        '{21'h01100, 21'h011FF, SCR_CJK}
    };

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        logic [15:0] seg_start;
        logic [16:0] seg_length;
        logic [4:0]  seg_script;
        logic        seg_is_rtl;
        logic        final_segment;
        logic        text_rtl;
    } out_t;

    // Segments produced by one byte: a script break first, then the final one.
    typedef struct packed {
        logic [1:0] num;
        out_t       seg0;
        out_t       seg1;
    } emit_t;

    function automatic logic is_rtl(input logic [4:0] script);
        return (script == SCR_ARABIC) || (script == SCR_HEBREW);
    endfunction

endpackage

### rtl/usrs_classify.sv
`timescale 1ns / 1ps
// ============================================================================
// usrs_classify
// Maps a codepoint to its script class by parallel compares against the
// range table.
// ============================================================================
module usrs_classify (
    input  logic [20:0] codepoint,
    output logic [4:0]  script
);

    // Ranges of different classes never overlap, so the hits can simply be
    // ORed together instead of going through a priority chain.
    always_comb begin
        script = usrs_pkg::SCR_UNKNOWN;
        for (int i = 0; i < usrs_pkg::NUM_SPANS; i++) begin
            if (codepoint >= usrs_pkg::SPANS[i].lo && codepoint <= usrs_pkg::SPANS[i].hi) begin
                script = script | usrs_pkg::SPANS[i].cls;
            end
        end
    end

endmodule

### rtl/usrs_core.sv
`timescale 1ns / 1ps
// ============================================================================
// usrs_core
// UTF-8 decode, run tracking and segment generation for one byte per cycle while fire is high.
// ============================================================================
module usrs_core #(
    parameter int MAX_TEXT_BYTES = 65536
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            fire,
    input  usrs_pkg::in_t   byte_in,
    output usrs_pkg::emit_t emit
);

    localparam int OFS_W = $clog2(MAX_TEXT_BYTES + 1);
    localparam int ST_W  = $clog2(MAX_TEXT_BYTES);

    logic [20:0]      part_reg, part_next, part_upd;
    logic [1:0]       pend_reg, pend_next, pend_upd;
    logic [OFS_W-1:0] off_reg, off_next, off_upd;
    logic [ST_W-1:0]  cps_reg, cps_next, cps_upd;
    logic [ST_W-1:0]  sst_reg, sst_next, sst_upd;
    logic [4:0]       cur_reg, cur_next, cur_upd;
    logic             have_reg, have_next, have_upd;
    logic [16:0]      rtl_reg, rtl_next, rtl_upd;
    logic [16:0]      ltr_reg, ltr_next, ltr_upd;
    logic             ended_reg, ended_next;

    logic [20:0] cp_val;
    logic [4:0]  cp_script;
    logic        take;
    logic        zero_end;
    logic        brk;
    logic        fin;
    usrs_pkg::out_t brk_seg, fin_seg;

    function automatic usrs_pkg::out_t make_seg(input logic [ST_W-1:0] start,
                                                input logic [OFS_W-1:0] end_ofs,
                                                input logic [4:0] script,
                                                input logic is_final,
                                                input logic vote);
        usrs_pkg::out_t s;
        logic [OFS_W-1:0] start_ext;
        logic [OFS_W-1:0] len;
        logic [31:0] start_w;
        logic [31:0] len_w;
        start_ext = OFS_W'(start);
        len       = (end_ofs >= start_ext) ? end_ofs - start_ext : '0;
        start_w   = 32'(start);
        len_w     = 32'(len);
        s.seg_start     = start_w[15:0];
        s.seg_length    = len_w[16:0];
        s.seg_script    = script;
        s.seg_is_rtl    = usrs_pkg::is_rtl(script);
        s.final_segment = is_final;
        s.text_rtl      = vote;
        return s;
    endfunction

    // Byte decode.
    always_comb begin
        logic [7:0] b;
        logic       single;
        logic [7:0] sval;
        b        = byte_in.text_byte;
        single   = 1'b0;
        sval     = '0;
        part_upd = part_reg;
        pend_upd = pend_reg;
        cps_upd  = cps_reg;
        zero_end = 1'b0;
        take     = 1'b0;
        off_upd  = (off_reg < OFS_W'(MAX_TEXT_BYTES)) ? off_reg + 1'b1 : off_reg;
        if (pend_reg == 2'd0) begin
            if (b == 8'd0) begin
                zero_end = 1'b1;
            end else begin
                cps_upd = (off_reg < OFS_W'(MAX_TEXT_BYTES - 1))
                        ? ST_W'(off_reg) : ST_W'(MAX_TEXT_BYTES - 1);
                if (!b[7]) begin
                    single = 1'b1;
                    sval   = b;
                end else if ((b & usrs_pkg::LEAD2_MASK) == usrs_pkg::LEAD2_PAT) begin
                    part_upd = {10'd0, b[4:0], 6'd0};
                    pend_upd = 2'd1;
                end else if ((b & usrs_pkg::LEAD3_MASK) == usrs_pkg::LEAD3_PAT) begin
                    part_upd = {5'd0, b[3:0], 12'd0};
                    pend_upd = 2'd2;
                end else if ((b & usrs_pkg::LEAD4_MASK) == usrs_pkg::LEAD4_PAT) begin
                    part_upd = {b[2:0], 18'd0};
                    pend_upd = 2'd3;
                end else begin
                    // Bad lead byte: a codepoint of value zero.
                    single = 1'b1;
                end
            end
            take = !zero_end && (single || (byte_in.last_byte && pend_upd != 2'd0));
        end else begin
            pend_upd = pend_reg - 2'd1;
            case (pend_upd)
                2'd0:    part_upd = part_reg | {15'd0, b[5:0]};
                2'd1:    part_upd = part_reg | {9'd0, b[5:0], 6'd0};
                default: part_upd = part_reg | {3'd0, b[5:0], 12'd0};
            endcase
            // Either the sequence completes, or the last byte forces it out.
            take = (pend_upd == 2'd0) || byte_in.last_byte;
        end
        if (ended_reg) begin
            take = 1'b0;
        end
        cp_val = single ? {13'd0, sval} : part_upd;
    end

    usrs_classify u_classify (
        .codepoint (cp_val),
        .script    (cp_script)
    );

    // Run tracking and segment generation.
    always_comb begin
        sst_upd  = sst_reg;
        cur_upd  = cur_reg;
        have_upd = have_reg;
        rtl_upd  = rtl_reg;
        ltr_upd  = ltr_reg;
        brk      = 1'b0;
        brk_seg  = make_seg(sst_reg, OFS_W'(cps_upd), cur_reg, 1'b0, 1'b0);
        if (take) begin
            if (!have_reg) begin
                have_upd = 1'b1;
                cur_upd  = cp_script;
                sst_upd  = cps_upd;
            end else if (cp_script != usrs_pkg::SCR_NEUTRAL && cp_script != cur_reg) begin
                brk = 1'b1;
                if (usrs_pkg::is_rtl(cur_reg)) begin
                    if (rtl_upd != usrs_pkg::CNT_MAX) rtl_upd = rtl_upd + 17'd1;
                end else if (cur_reg != usrs_pkg::SCR_NEUTRAL
                             && cur_reg != usrs_pkg::SCR_EMOJI) begin
                    if (ltr_upd != usrs_pkg::CNT_MAX) ltr_upd = ltr_upd + 17'd1;
                end
                sst_upd = cps_upd;
                cur_upd = cp_script;
            end
        end
        fin = !ended_reg && (zero_end || byte_in.last_byte) && have_upd;
        if (fin) begin
            if (usrs_pkg::is_rtl(cur_upd)) begin
                if (rtl_upd != usrs_pkg::CNT_MAX) rtl_upd = rtl_upd + 17'd1;
            end else if (cur_upd != usrs_pkg::SCR_NEUTRAL
                         && cur_upd != usrs_pkg::SCR_EMOJI) begin
                if (ltr_upd != usrs_pkg::CNT_MAX) ltr_upd = ltr_upd + 17'd1;
            end
        end
        fin_seg = make_seg(sst_upd, zero_end ? off_reg : off_upd, cur_upd, 1'b1,
                           rtl_upd > ltr_upd);
        emit.num  = fire ? (2'(brk) + 2'(fin)) : 2'd0;
        emit.seg0 = brk ? brk_seg : fin_seg;
        emit.seg1 = fin_seg;
    end

    // Next state: the end of a text returns the run state to its reset value; after a zero terminator ended_reg is set.
    always_comb begin
        part_next  = part_upd;
        pend_next  = pend_upd;
        off_next   = off_upd;
        cps_next   = cps_upd;
        sst_next   = sst_upd;
        cur_next   = cur_upd;
        have_next  = have_upd;
        rtl_next   = rtl_upd;
        ltr_next   = ltr_upd;
        ended_next = 1'b0;
        if (ended_reg || zero_end || byte_in.last_byte) begin
            part_next  = '0;
            pend_next  = '0;
            off_next   = '0;
            cps_next   = '0;
            sst_next   = '0;
            cur_next   = usrs_pkg::SCR_UNKNOWN;
            have_next  = 1'b0;
            rtl_next   = '0;
            ltr_next   = '0;
            if (ended_reg) begin
                ended_next = !byte_in.last_byte;
            end else begin
                ended_next = zero_end && !byte_in.last_byte;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            part_reg  <= '0;
            pend_reg  <= '0;
            off_reg   <= '0;
            cps_reg   <= '0;
            sst_reg   <= '0;
            cur_reg   <= usrs_pkg::SCR_UNKNOWN;
            have_reg  <= 1'b0;
            rtl_reg   <= '0;
            ltr_reg   <= '0;
            ended_reg <= 1'b0;
        end else if (fire) begin
            part_reg  <= part_next;
            pend_reg  <= pend_next;
            off_reg   <= off_next;
            cps_reg   <= cps_next;
            sst_reg   <= sst_next;
            cur_reg   <= cur_next;
            have_reg  <= have_next;
            rtl_reg   <= rtl_next;
            ltr_reg   <= ltr_next;
            ended_reg <= ended_next;
        end
    end

    // After a zero lead byte the run state has been cleared.
    a_ended_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        ended_reg |-> (!have_reg && pend_reg == 2'd0))
        else $error("usrs_core: run state left over after end of text");

    // Two segments from one byte are always a break followed by the final one.
    a_two_order: assert property (@(posedge aclk) disable iff (!aresetn)
        emit.num == 2'd2 |-> (emit.seg1.final_segment && !emit.seg0.final_segment))
        else $error("usrs_core: bad segment order");

endmodule

### rtl/usrs_out_fifo.sv
`timescale 1ns / 1ps
// ============================================================================
// usrs_out_fifo
// Small result queue that takes up to two segments per cycle and hands them
// out one per transfer.
// ============================================================================
module usrs_out_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  usrs_pkg::emit_t push,
    output logic            room,
    output logic            m_valid,
    input  logic            m_ready,
    output usrs_pkg::out_t  m_data
);

    usrs_pkg::out_t mem [usrs_pkg::OUT_DEPTH];

    logic [usrs_pkg::OUT_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [usrs_pkg::OUT_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [usrs_pkg::OUT_CNT_W-1:0] count_reg, count_next;
    logic                           pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != '0);
    assign m_data  = mem[rd_ptr_reg];
    // Room for a worst-case byte, which yields two segments.
    assign room    = (count_reg <= usrs_pkg::OUT_CNT_W'(usrs_pkg::OUT_DEPTH - 2));

    always_comb begin
        wr_ptr_next = wr_ptr_reg + usrs_pkg::OUT_PTR_W'(push.num);
        rd_ptr_next = rd_ptr_reg + usrs_pkg::OUT_PTR_W'(pop);
        count_next  = count_reg + usrs_pkg::OUT_CNT_W'(push.num)
                    - usrs_pkg::OUT_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.num != 2'd0) begin
            mem[wr_ptr_reg] <= push.seg0;
        end
        if (push.num == 2'd2) begin
            mem[wr_ptr_reg + usrs_pkg::OUT_PTR_W'(1)] <= push.seg1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= usrs_pkg::OUT_CNT_W'(usrs_pkg::OUT_DEPTH))
        else $error("usrs_out_fifo: count beyond depth");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push.num != 2'd0 |-> room)
        else $error("usrs_out_fifo: push without room");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> count_reg == $past(count_reg)
            + usrs_pkg::OUT_CNT_W'($past(push.num)) - usrs_pkg::OUT_CNT_W'($past(pop)))
        else $error("usrs_out_fifo: count does not follow pushes and pops");

endmodule

### rtl/utf8_script_run_segmenter.sv
`timescale 1ns / 1ps
// ============================================================================
// utf8_script_run_segmenter
// Splits a UTF-8 byte stream into runs of one script and reports each run
// as a byte-offset segment, with a right-to-left vote on the last one.
// ============================================================================
// Usage:
//   s_valid/s_ready/s_data carry one text byte per transfer; last_byte marks
//   the end of a text, and a zero byte in lead position also ends it.
//   m_valid/m_ready/m_data carry one segment per transfer, in text order.
// Timing:
//   A byte is captured in an input register; once the result queue has room
//   it is decoded, classified and turned into segments, which are written to a
//   four-entry result queue. A segment is offered on m_data after the queue
//   has registered it. One byte is taken every cycle while the queue has
//   room; a byte that closes a run and ends the text gives two segments,
//   which leave the queue one per transfer.
// Stalls and reset:
//   While the receiver holds m_ready low the queue fills; s_ready drops once
//   fewer than two entries are free and the byte waits in the input register.
//   Reset empties the queue, clears the input register's valid flag and all run state.
// ============================================================================
module utf8_script_run_segmenter #(
    parameter int MAX_TEXT_BYTES = 65536
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  usrs_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output usrs_pkg::out_t m_data
);

    usrs_pkg::in_t   in_data_reg;
    logic            in_valid_reg, in_valid_next;
    logic            room;
    logic            fire;
    usrs_pkg::emit_t emit;

    assign fire    = in_valid_reg && room;
    assign s_ready = !in_valid_reg || room;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    usrs_core #(
        .MAX_TEXT_BYTES (MAX_TEXT_BYTES)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .byte_in (in_data_reg),
        .emit    (emit)
    );

    usrs_out_fifo u_out_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (emit),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

### tb/sv/tb_utf8_script_run_segmenter.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_utf8_script_run_segmenter
// Self-checking bench for the UTF-8 script run segmenter. Text bytes are
// driven over the input channel and a local model of the decoder, the script
// classifier and the run tracker predicts every segment. Each segment is
// checked against the oldest prediction. Stimulus covers directed corner
// cases, random well-formed and broken texts under varying idle patterns,
// and a long receiver hold-off.
// ============================================================================
module tb_utf8_script_run_segmenter;

    localparam int TEXT_LIMIT  = 65536;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int NUM_RANGES  = 54;

    typedef struct packed {
        logic [20:0] lo;
        logic [20:0] hi;
        logic [4:0]  script;
    } script_range_t;

    // The first matching range wins; ranges of different scripts do not overlap.
    localparam script_range_t SCRIPT_RANGES [NUM_RANGES] = '{
        '{21'h1F300, 21'h1F9FF, usrs_pkg::SCR_EMOJI},
        '{21'h02600, 21'h026FF, usrs_pkg::SCR_EMOJI},
        '{21'h02700, 21'h027BF, usrs_pkg::SCR_EMOJI},
        '{21'h0FE00, 21'h0FE0F, usrs_pkg::SCR_EMOJI},
        '{21'h1F000, 21'h1F02F, usrs_pkg::SCR_EMOJI},
        '{21'h1F0A0, 21'h1F0FF, usrs_pkg::SCR_EMOJI},
        '{21'h1FA70, 21'h1FAFF, usrs_pkg::SCR_EMOJI},
        '{21'h1F3FB, 21'h1F3FF, usrs_pkg::SCR_EMOJI},
        '{21'h0200D, 21'h0200D, usrs_pkg::SCR_EMOJI},
        '{21'h1F1E6, 21'h1F1FF, usrs_pkg::SCR_EMOJI},
        '{21'h00030, 21'h00039, usrs_pkg::SCR_DIGIT},
        '{21'h00020, 21'h00020, usrs_pkg::SCR_NEUTRAL},
        '{21'h0003A, 21'h0003A, usrs_pkg::SCR_NEUTRAL},
        '{21'h0002C, 21'h0002C, usrs_pkg::SCR_NEUTRAL},
        '{21'h0002E, 21'h0002E, usrs_pkg::SCR_NEUTRAL},
        '{21'h0002D, 21'h0002D, usrs_pkg::SCR_NEUTRAL},
        '{21'h00028, 21'h00028, usrs_pkg::SCR_NEUTRAL},
        '{21'h00029, 21'h00029, usrs_pkg::SCR_NEUTRAL},
        '{21'h0003D, 21'h0003D, usrs_pkg::SCR_NEUTRAL},
        '{21'h00022, 21'h00022, usrs_pkg::SCR_NEUTRAL},
        '{21'h00041, 21'h0005A, usrs_pkg::SCR_LATIN},
        '{21'h00061, 21'h0007A, usrs_pkg::SCR_LATIN},
        '{21'h000C0, 21'h000FF, usrs_pkg::SCR_LATIN},
        '{21'h00100, 21'h0017F, usrs_pkg::SCR_LATIN},
        '{21'h00180, 21'h0024F, usrs_pkg::SCR_LATIN},
        '{21'h00600, 21'h006FF, usrs_pkg::SCR_ARABIC},
        '{21'h0FB50, 21'h0FDFF, usrs_pkg::SCR_ARABIC},
        '{21'h0FE70, 21'h0FEFF, usrs_pkg::SCR_ARABIC},
        '{21'h00590, 21'h005FF, usrs_pkg::SCR_HEBREW},
        '{21'h00400, 21'h004FF, usrs_pkg::SCR_CYRILLIC},
        '{21'h00500, 21'h0052F, usrs_pkg::SCR_CYRILLIC},
        '{21'h00370, 21'h003FF, usrs_pkg::SCR_GREEK},
        '{21'h01F00, 21'h01FFF, usrs_pkg::SCR_GREEK},
        '{21'h00E00, 21'h00E7F, usrs_pkg::SCR_THAI},
        '{21'h00900, 21'h0097F, usrs_pkg::SCR_DEVANAGARI},
        '{21'h00980, 21'h009FF, usrs_pkg::SCR_BENGALI},
        '{21'h00B80, 21'h00BFF, usrs_pkg::SCR_TAMIL},
        '{21'h00C00, 21'h00C7F, usrs_pkg::SCR_TELUGU},
        '{21'h00C80, 21'h00CFF, usrs_pkg::SCR_KANNADA},
        '{21'h00D00, 21'h00D7F, usrs_pkg::SCR_MALAYALAM},
        '{21'h00A80, 21'h00AFF, usrs_pkg::SCR_GUJARATI},
        '{21'h04E00, 21'h09FFF, usrs_pkg::SCR_CJK},
        '{21'h03400, 21'h04DBF, usrs_pkg::SCR_CJK},
        '{21'h20000, 21'h2A6DF, usrs_pkg::SCR_CJK},
        '{21'h2A700, 21'h2B73F, usrs_pkg::SCR_CJK},
        '{21'h2B740, 21'h2B81F, usrs_pkg::SCR_CJK},
        '{21'h2B820, 21'h2CEAF, usrs_pkg::SCR_CJK},
        '{21'h0F900, 21'h0FAFF, usrs_pkg::SCR_CJK},
        '{21'h03040, 21'h0309F, usrs_pkg::SCR_CJK},
        '{21'h030A0, 21'h030FF, usrs_pkg::SCR_CJK},
        '{21'h031F0, 21'h031FF, usrs_pkg::SCR_CJK},
        '{21'h03190, 21'h0319F, usrs_pkg::SCR_CJK},
        '{21'h0AC00, 21'h0D7AF, usrs_pkg::SCR_CJK},
        '{21'h01100, 21'h011FF, usrs_pkg::SCR_CJK}
    };

    localparam logic [7:0] NEUTRAL_CHARS [9] = '{
        8'h20, 8'h3A, 8'h2C, 8'h2E, 8'h2D, 8'h28, 8'h29, 8'h3D, 8'h22
    };

    logic           aclk    = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    usrs_pkg::in_t  s_data  = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    usrs_pkg::out_t m_data;

    utf8_script_run_segmenter #(
        .MAX_TEXT_BYTES(TEXT_LIMIT)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predicted segments, oldest first.
    usrs_pkg::out_t expected_segs [$];

    // Model of the run tracker.
    logic [20:0] cp_acc;
    logic [1:0]  pend;
    logic [16:0] offset;
    logic [15:0] cp_start;
    logic [15:0] run_start;
    logic [4:0]  run_script;
    logic        seen_first;
    logic [16:0] rtl_runs;
    logic [16:0] ltr_runs;
    logic        text_closed;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int live_bytes    = 0;
    int err_count     = 0;
    int hold_reqs     = 0;
    int hold_done     = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    logic [7:0] text_bytes [$];

    function automatic logic [4:0] script_of(input logic [20:0] cp);
        for (int i = 0; i < NUM_RANGES; i++) begin
            if (cp >= SCRIPT_RANGES[i].lo && cp <= SCRIPT_RANGES[i].hi)
                return SCRIPT_RANGES[i].script;
        end
        return usrs_pkg::SCR_UNKNOWN;
    endfunction

    task automatic clear_text();
        cp_acc      = '0;
        pend        = '0;
        offset      = '0;
        cp_start    = '0;
        run_start   = '0;
        run_script  = usrs_pkg::SCR_UNKNOWN;
        seen_first  = 1'b0;
        rtl_runs    = '0;
        ltr_runs    = '0;
        text_closed = 1'b0;
    endtask

    task automatic close_run(input logic [16:0] end_off, input logic is_final);
        usrs_pkg::out_t seg;
        logic rtl;
        rtl = (run_script == usrs_pkg::SCR_ARABIC) || (run_script == usrs_pkg::SCR_HEBREW);
        if (rtl) begin
            if (rtl_runs != usrs_pkg::CNT_MAX) rtl_runs = rtl_runs + 1'b1;
        end else if (run_script != usrs_pkg::SCR_NEUTRAL
                     && run_script != usrs_pkg::SCR_EMOJI) begin
            if (ltr_runs != usrs_pkg::CNT_MAX) ltr_runs = ltr_runs + 1'b1;
        end
        seg.seg_start     = run_start;
        seg.seg_length    = (end_off >= {1'b0, run_start}) ? end_off - {1'b0, run_start} : '0;
        seg.seg_script    = run_script;
        seg.seg_is_rtl    = rtl;
        seg.final_segment = is_final;
        seg.text_rtl      = is_final && (rtl_runs > ltr_runs);
        expected_segs.insert(expected_segs.size(), seg);
    endtask

    task automatic take_codepoint(input logic [20:0] cp);
        logic [4:0] s;
        s = script_of(cp);
        if (!seen_first) begin
            seen_first = 1'b1;
            run_script = s;
            run_start  = cp_start;
        end else if (s != usrs_pkg::SCR_NEUTRAL && s != run_script) begin
            close_run({1'b0, cp_start}, 1'b0);
            run_start  = cp_start;
            run_script = s;
        end
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic last);
        if (text_closed) begin
            // Bytes after a zero terminator are dropped up to the last one.
            if (last) clear_text();
            return;
        end
        live_bytes++;
        if (pend == 2'd0) begin
            if (b == 8'h00) begin
                if (seen_first) close_run(offset, 1'b1);
                clear_text();
                text_closed = !last;
                return;
            end
            cp_start = (offset < TEXT_LIMIT - 1) ? offset[15:0] : 16'(TEXT_LIMIT - 1);
            if (b < 8'h80) begin
                take_codepoint({13'd0, b});
            end else if ((b & usrs_pkg::LEAD2_MASK) == usrs_pkg::LEAD2_PAT) begin
                cp_acc = {10'd0, b[4:0], 6'd0};
                pend   = 2'd1;
            end else if ((b & usrs_pkg::LEAD3_MASK) == usrs_pkg::LEAD3_PAT) begin
                cp_acc = {5'd0, b[3:0], 12'd0};
                pend   = 2'd2;
            end else if ((b & usrs_pkg::LEAD4_MASK) == usrs_pkg::LEAD4_PAT) begin
                cp_acc = {b[2:0], 18'd0};
                pend   = 2'd3;
            end else begin
                take_codepoint('0);
            end
        end else begin
            pend   = pend - 2'd1;
            cp_acc = cp_acc | ({15'd0, b[5:0]} << (6 * pend));
            if (pend == 2'd0) take_codepoint(cp_acc);
        end
        if (offset < TEXT_LIMIT) offset = offset + 1'b1;
        if (last) begin
            // An unfinished sequence is closed with zero payload bits.
            if (pend != 2'd0) begin
                pend = 2'd0;
                take_codepoint(cp_acc);
            end
            if (seen_first) close_run(offset, 1'b1);
            clear_text();
        end
    endtask

    // Offers one byte and waits for its transfer, then updates the model.
    task automatic push_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{text_byte: b, last_byte: last};
        do @(posedge aclk); while (!s_ready);
        predict_byte(b, last);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_segs.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    function automatic logic [7:0] cont_byte(input logic [5:0] bits);
        logic [1:0] top;
        // Continuation bytes are not checked, so their top bits vary now and then.
        top = ($urandom_range(19) == 0) ? 2'($urandom_range(3)) : 2'b10;
        return {top, bits};
    endfunction

    task automatic encode_cp(input logic [20:0] cp);
        if (cp < 21'h80) begin
            text_bytes.insert(text_bytes.size(), cp[7:0]);
        end else if (cp < 21'h800) begin
            text_bytes.insert(text_bytes.size(), {3'b110, cp[10:6]});
            text_bytes.insert(text_bytes.size(), cont_byte(cp[5:0]));
        end else if (cp < 21'h10000) begin
            text_bytes.insert(text_bytes.size(), {4'b1110, cp[15:12]});
            text_bytes.insert(text_bytes.size(), cont_byte(cp[11:6]));
            text_bytes.insert(text_bytes.size(), cont_byte(cp[5:0]));
        end else begin
            text_bytes.insert(text_bytes.size(), {5'b11110, cp[20:18]});
            text_bytes.insert(text_bytes.size(), cont_byte(cp[17:12]));
            text_bytes.insert(text_bytes.size(), cont_byte(cp[11:6]));
            text_bytes.insert(text_bytes.size(), cont_byte(cp[5:0]));
        end
    endtask

    function automatic logic [20:0] pick_in_range(input int idx);
        logic [20:0] lo;
        logic [20:0] hi;
        int r;
        lo = SCRIPT_RANGES[idx].lo;
        hi = SCRIPT_RANGES[idx].hi;
        r  = $urandom_range(9);
        if (r == 0) return lo;
        if (r == 1) return hi;
        return lo + 21'($urandom_range(hi - lo));
    endfunction

    task automatic send_random_text();
        logic [20:0] cp;
        logic [7:0]  bad;
        int n_cp;
        int sel;
        int span;
        int shape;
        int tail;
        if ($urandom_range(49) == 0) begin
            push_byte(8'h00, 1'b1);
            return;
        end
        text_bytes.delete();
        n_cp = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        span = $urandom_range(NUM_RANGES - 1);
        for (int i = 0; i < n_cp; i++) begin
            sel = $urandom_range(99);
            if (sel < 15) begin
                cp = {13'd0, NEUTRAL_CHARS[$urandom_range(8)]};
            end else if (sel < 55) begin
                cp = pick_in_range(span);
            end else if (sel < 90) begin
                span = $urandom_range(NUM_RANGES - 1);
                cp   = pick_in_range(span);
            end else if (sel < 95) begin
                cp = 21'($urandom_range(21'h1FFFFF, 1));
            end else begin
                cp = 21'($urandom_range(127, 1));
            end
            encode_cp(cp);
        end
        shape = $urandom_range(99);
        if (shape < 8) begin
            bad = $urandom_range(1) ? 8'($urandom_range(8'hBF, 8'h80))
                                    : 8'($urandom_range(8'hFF, 8'hF8));
            text_bytes.insert($urandom_range(text_bytes.size()), bad);
        end else if (shape < 14) begin
            text_bytes[$urandom_range(text_bytes.size() - 1)] = 8'($urandom_range(255));
        end else if (shape < 20 && text_bytes.size() > 2) begin
            // Drop the tail so the text may stop inside a sequence.
            repeat ($urandom_range(1, 2)) void'(text_bytes.pop_back());
        end
        tail = $urandom_range(99);
        for (int i = 0; i < text_bytes.size(); i++)
            push_byte(text_bytes[i], (tail < 80) && (i == text_bytes.size() - 1));
        if (tail >= 92) begin
            push_byte(8'h00, 1'b1);
        end else if (tail >= 80) begin
            push_byte(8'h00, 1'b0);
            repeat ($urandom_range(3)) push_byte(8'($urandom_range(255)), 1'b0);
            push_byte(8'($urandom_range(255)), 1'b1);
        end
    endtask

    task automatic test_directed();
        // Neutral first, then Latin, Hebrew, Arabic, and a digit that both
        // breaks the run and ends the text.
        push_byte(8'h20, 1'b0);
        push_byte(8'h61, 1'b0);
        push_byte(8'hD7, 1'b0);
        push_byte(8'h90, 1'b0);
        push_byte(8'hD8, 1'b0);
        push_byte(8'hA7, 1'b0);
        push_byte(8'h31, 1'b1);
        // Bad lead bytes, then a three-byte sequence cut short by the last byte.
        push_byte(8'hFF, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hF8, 1'b0);
        push_byte(8'hE4, 1'b0);
        push_byte(8'hB8, 1'b1);
        // Emoji, a zero continuation byte, a zero terminator and ignored bytes.
        push_byte(8'hF0, 1'b0);
        push_byte(8'h9F, 1'b0);
        push_byte(8'h98, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hC3, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h41, 1'b0);
        push_byte(8'h00, 1'b1);
        // Empty text, a lone unknown codepoint, and a right-to-left text.
        push_byte(8'h00, 1'b1);
        push_byte(8'h7F, 1'b1);
        push_byte(8'hD7, 1'b0);
        push_byte(8'h90, 1'b1);
    endtask

    task automatic test_random_texts(input int n);
        int start;
        start = live_bytes;
        while (live_bytes - start < n) send_random_text();
    endtask

    // The receiver stops for a long time while every byte starts a new run,
    // so the result queue fills and the input side must stall.
    task automatic test_backpressure();
        hold_reqs++;
        for (int i = 0; i < 48; i++)
            push_byte((i % 2 == 0) ? 8'h61 : 8'h31, i == 47);
    endtask

    function automatic string seg_text(input usrs_pkg::out_t s);
        return $sformatf("start=%0d len=%0d script=%0d rtl=%0b final=%0b text_rtl=%0b",
                         s.seg_start, s.seg_length, s.seg_script, s.seg_is_rtl,
                         s.final_segment, s.text_rtl);
    endfunction

    task automatic flag_error(input string msg);
        err_count++;
        if (err_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // Receiver: random idling, plus a long hold-off on request.
    always @(posedge aclk) begin
        if (hold_reqs != hold_done) begin
            hold_done <= hold_done + 1;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Checks every segment transfer against the oldest prediction.
    always @(posedge aclk) begin
        usrs_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_segs.size() == 0) begin
                flag_error({"unexpected segment: ", seg_text(m_data)});
            end else begin
                want = expected_segs.pop_front();
                if (m_data.seg_start !== want.seg_start
                        || m_data.seg_length !== want.seg_length
                        || m_data.seg_script !== want.seg_script
                        || m_data.seg_is_rtl !== want.seg_is_rtl
                        || m_data.final_segment !== want.final_segment
                        || m_data.text_rtl !== want.text_rtl)
                    flag_error({"segment mismatch: expected ", seg_text(want),
                                " got ", seg_text(m_data)});
            end
        end
    end

    // Ends the run when no transfer happens on either side for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        clear_text();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 18;
        recv_idle_pct = 62;
        test_directed();
        test_random_texts(325);
        wait_drained();

        send_idle_pct = 62;
        recv_idle_pct = 18;
        test_random_texts(325);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_texts(325);
        test_backpressure();
        wait_drained();
        repeat (20) @(posedge aclk);

        if (err_count == 0 && expected_segs.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
